@@ hw/rtl/rle_row_pixel_decoder_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RLE_ROW_PIXEL_DECODER_CORE_DEFINES_SVH
`define RLE_ROW_PIXEL_DECODER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RLE_RPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RLE_RPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rle_rpd_pkg.sv @@
package rle_rpd_pkg;

  localparam int CFG_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int PIX_W     = 16;
  localparam int START_W   = 10;
  localparam int LEN_W     = 7;
  localparam int RUN_BIT   = 7;
  localparam int OUT_W     = 40;

  localparam int PIX_LSB   = 0;
  localparam int START_LSB = PIX_LSB + PIX_W;
  localparam int LEN_LSB   = START_LSB + START_W;
  localparam int PAD_W     = OUT_W - LEN_LSB - LEN_W;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_value;
    logic [START_W-1:0] start_column;
    logic [LEN_W-1:0]   span_length;
    logic               row_done;
  } span_t;

endpackage

@@ hw/rtl/rle_rpd_parse.sv @@
module rle_rpd_parse #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rle_rpd_pkg::CFG_W-1:0]  row_width,
  input  logic                         step,
  input  logic [rle_rpd_pkg::BYTE_W-1:0] data_byte,
  input  logic                         row_end,
  output logic                         emit,
  output rle_rpd_pkg::span_t           span
);
  import rle_rpd_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2047) ? CFG_W : $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0]  fill_column, fill_column_next;
  phase_t            phase, phase_next;
  logic              run_mode, run_mode_next;
  logic [LEN_W-1:0]  packet_count, packet_count_next;
  logic [BYTE_W-1:0] low_byte, low_byte_next;

  logic [CFG_W-1:0]  width_eff;
  logic [CFG_W-1:0]  fill_ext;
  logic [CFG_W-1:0]  room;
  logic [CFG_W-1:0]  fill_sum;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  count_dec;
  logic              have;

  assign width_eff = (row_width > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : row_width;
  assign fill_ext  = CFG_W'(fill_column);
  assign room      = width_eff - fill_ext;
  assign count_dec = packet_count - LEN_W'(1);

  always_comb begin
    fill_column_next  = fill_column;
    phase_next        = phase;
    run_mode_next     = run_mode;
    packet_count_next = packet_count;
    low_byte_next     = low_byte;
    len               = '0;
    have              = 1'b0;
    fill_sum          = fill_ext;
    if (fill_ext < width_eff) begin
      unique case (phase)
        PH_LOW: begin
          low_byte_next = data_byte;
          phase_next    = PH_HIGH;
        end
        PH_HIGH: begin
          if (run_mode) begin
            len = (CFG_W'(packet_count) < room) ? packet_count : room[LEN_W-1:0];
            phase_next        = PH_CTRL;
            packet_count_next = '0;
          end else begin
            len               = LEN_W'(1);
            packet_count_next = count_dec;
            phase_next        = (count_dec != '0) ? PH_LOW : PH_CTRL;
          end
          fill_sum         = fill_ext + CFG_W'(len);
          fill_column_next = fill_sum[COL_W-1:0];
          have             = (len != '0);
        end
        default: begin
          packet_count_next = data_byte[LEN_W-1:0];
          run_mode_next     = data_byte[RUN_BIT];
          phase_next        = (data_byte[RUN_BIT] || data_byte[LEN_W-1:0] != '0) ?
                              PH_LOW : PH_CTRL;
        end
      endcase
    end
    if (row_end) begin
      fill_column_next  = '0;
      phase_next        = PH_CTRL;
      run_mode_next     = 1'b0;
      packet_count_next = '0;
      low_byte_next     = '0;
    end
  end

  always_comb begin
    emit = have || row_end;
    span.pixel_value  = have ? {data_byte, low_byte} : '0;
    span.start_column = have ? fill_ext[START_W-1:0] : '0;
    span.span_length  = have ? len : '0;
    span.row_done     = row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_column  <= '0;
      phase        <= PH_CTRL;
      run_mode     <= 1'b0;
      packet_count <= '0;
      low_byte     <= '0;
    end else if (step) begin
      fill_column  <= fill_column_next;
      phase        <= phase_next;
      run_mode     <= run_mode_next;
      packet_count <= packet_count_next;
      low_byte     <= low_byte_next;
    end
  end

endmodule

@@ hw/rtl/rle_row_pixel_decoder_core.sv @@
// A byte taken into the input register gives its span to the output register.
// Throughput: 1 byte per cycle unless a span waits on the output; the parse state
// updates once per byte in one pass of logic between the input and output registers.
// Bytes that give no span leave the block without taking the output register.
// Reset (rst, synchronous, active high) empties both registers, rearms the parser
// for a new row and sets row_width to 1024.
module rle_row_pixel_decoder_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rle_rpd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // data_byte
  input  logic                          s_tlast,  // row_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rle_rpd_pkg::OUT_W-1:0] m_tdata,  // pixel_value, start_column, span_length
  output logic                          m_tlast   // row_done
);
  import rle_rpd_pkg::*;

  logic [CFG_W-1:0]  row_width;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              out_valid;
  span_t             out_span;

  logic  emit;
  span_t span;
  logic  out_free;
  logic  proc_fire;

  assign out_free  = !out_valid || m_tready;
  assign proc_fire = in_valid && (out_free || !emit);
  assign s_tready  = !in_valid || proc_fire;

  rle_rpd_parse #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .step      (proc_fire),
    .data_byte (in_byte),
    .row_end   (in_last),
    .emit      (emit),
    .span      (span)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // hold the input byte until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_span <= span;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_span.span_length, out_span.start_column,
                     out_span.pixel_value};
  assign m_tlast  = out_span.row_done;

endmodule

@@ hw/rtl/rle_rpd_checker.sv @@
`include "rle_row_pixel_decoder_core_defines.svh"

module rle_rpd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rle_rpd_pkg::OUT_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import rle_rpd_pkg::*;

  logic [LEN_W-1:0]   chk_len;
  logic [START_W-1:0] chk_start;
  logic [PIX_W-1:0]   chk_pix;

  assign chk_len   = m_tdata[LEN_LSB +: LEN_W];
  assign chk_start = m_tdata[START_LSB +: START_W];
  assign chk_pix   = m_tdata[PIX_LSB +: PIX_W];

  `RLE_RPD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  `RLE_RPD_ASSERT(a_span_nonempty, m_tvalid && !m_tlast |-> chk_len != '0, "empty span without row end")
  `RLE_RPD_ASSERT(a_empty_row_end, m_tvalid && m_tlast && chk_len == '0 |-> chk_pix == '0 && chk_start == '0, "empty row end carries data")
  `RLE_RPD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind rle_row_pixel_decoder_core rle_rpd_checker u_rle_rpd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
